FILE: hw/rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, destination codes and handshake structs of the correlation
// block and its shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_PAIRS_DEF   = 4096;

	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 13;
	localparam int SX_W     = 29;
	// a full set of -32768 pairs reaches +2^42 in both sums
	localparam int SXY_W    = 44;
	localparam int SSQ_W    = 43;
	localparam int LIMB_W   = 32;
	localparam int PROD_W   = 2 * LIMB_W;
	localparam int OPD_W    = 4 * LIMB_W;
	localparam int ACC_W    = 6 * LIMB_W;
	localparam int COEF_W   = 16;

	// where a finished partial product goes
	localparam logic [1:0] DST_ACC = 2'd0;
	localparam logic [1:0] DST_XY  = 2'd1;
	localparam logic [1:0] DST_XX  = 2'd2;
	localparam logic [1:0] DST_YY  = 2'd3;

	typedef struct packed {
		logic                issue;
		logic [LIMB_W-1:0]   a;
		logic [LIMB_W-1:0]   b;
		logic [2:0]          sh;
		logic                neg;
		logic [1:0]          dest;
	} mul_req_t;

	typedef struct packed {
		logic                valid;
		logic [PROD_W-1:0]   p;
		logic [2:0]          sh;
		logic                neg;
		logic [1:0]          dest;
	} mul_rsp_t;

endpackage

FILE: hw/rtl/pearson_correlation.sv
// Intake: pair_stall holds further pairs while the P1, P2 and P3 states issue the three products
// of the taken pair through the shared multiplier. After the last pair, the 32x32 multiplier
// runs the limb products of the sums, the denominator and a 16-step root search.
// A zero denominator ends the work after the DY2 op; an overflowed set finishes on its last pair.
// Result back-pressure adds its stall cycles; intake stays stalled meanwhile.
// Reset clears the count, the sums and the result valid; the block is ready right after.
// ----------------------------------------------------------------------------
// pearson_correlation
// Streams signed sample pairs into running sums and, on the last pair, forms
// the correlation coefficient in Q1.15 by an exact bitwise search.
// ----------------------------------------------------------------------------
module pearson_correlation #(
	parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_PAIRS   = pcc_pkg::MAX_PAIRS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pair_valid,
	output logic                              pair_stall,
	input  logic signed [pcc_pkg::SAMPLE_W-1:0] sample_x,
	input  logic signed [pcc_pkg::SAMPLE_W-1:0] sample_y,
	input  logic                              last,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [pcc_pkg::COEF_W-1:0] coefficient,
	output logic                              valid_res,
	output logic [pcc_pkg::CNT_W-1:0]         pairs_used
);
	import pcc_pkg::*;

	localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_P1     = 4'd1;
	localparam logic [3:0] S_P2     = 4'd2;
	localparam logic [3:0] S_P3     = 4'd3;
	localparam logic [3:0] S_PDRAIN = 4'd4;
	localparam logic [3:0] S_STORE  = 4'd5;
	localparam logic [3:0] S_ISSUE  = 4'd6;
	localparam logic [3:0] S_DRAIN  = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	localparam logic [3:0] OP_START = 4'd0;
	localparam logic [3:0] OP_NUM1  = 4'd1;
	localparam logic [3:0] OP_NUM2  = 4'd2;
	localparam logic [3:0] OP_DX1   = 4'd3;
	localparam logic [3:0] OP_DX2   = 4'd4;
	localparam logic [3:0] OP_DY1   = 4'd5;
	localparam logic [3:0] OP_DY2   = 4'd6;
	localparam logic [3:0] OP_DEN   = 4'd7;
	localparam logic [3:0] OP_LIM   = 4'd8;
	localparam logic [3:0] OP_SQ    = 4'd9;
	localparam logic [3:0] OP_TST   = 4'd10;

	logic [3:0]               state_q;
	logic [3:0]               op_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic signed [SX_W-1:0]   sx_q;
	logic signed [SX_W-1:0]   sy_q;
	logic signed [SXY_W-1:0]  sxy_q;
	logic [SSQ_W-1:0]         sxx_q;
	logic [SSQ_W-1:0]         syy_q;

	logic [SAMPLE_W-1:0]      xm_q;
	logic [SAMPLE_W-1:0]      ym_q;
	logic                     sxor_q;
	logic                     last_q;

	logic [OPD_W-1:0]         opa_q;
	logic [OPD_W-1:0]         opb_q;
	logic [1:0]               lal_q;
	logic [1:0]               lbl_q;
	logic [1:0]               i_q;
	logic [1:0]               j_q;
	logic                     neg_q;

	logic [PROD_W-1:0]        num_q;
	logic                     num_neg_q;
	logic [PROD_W-1:0]        dx_q;
	logic [OPD_W-1:0]         den_q;
	logic [ACC_W-1:0]         lim_q;
	logic [COEF_W-1:0]        q_q;
	logic [COEF_W-1:0]        cand_q;
	logic [3:0]               bit_q;
	logic                     fin_ok_q;

	logic                     res_valid_q;
	logic [COEF_W-1:0]        coef_q;
	logic                     valid_res_q;
	logic [CNT_W-1:0]         pairs_q;

	logic signed [SAMPLE_W-1:0] x_sh;
	logic signed [SAMPLE_W-1:0] y_sh;
	logic signed [SAMPLE_W-1:0] x_v;
	logic signed [SAMPLE_W-1:0] y_v;

	logic [SXY_W-1:0]         sxy_mag;
	logic [SX_W-1:0]          sx_mag;
	logic [SX_W-1:0]          sy_mag;
	logic [PROD_W-1:0]        num_mag;
	logic [COEF_W-1:0]        q_next;
	logic [COEF_W-1:0]        coef_w;
	logic                     pair_acc;
	logic                     den_ok;
	logic                     store_fin;

	mul_req_t                 req;
	mul_rsp_t                 rsp;
	logic                     acc_load;
	logic [ACC_W-1:0]         acc_init;
	logic [ACC_W-1:0]         acc;

	pcc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.acc_load (acc_load),
		.acc_init (acc_init),
		.acc      (acc),
		.rsp      (rsp)
	);

	// keep only the low SAMPLE_BITS bits, read as two's complement
	assign x_sh = sample_x <<< SHIFT;
	assign y_sh = sample_y <<< SHIFT;
	assign x_v  = x_sh >>> SHIFT;
	assign y_v  = y_sh >>> SHIFT;

	assign pair_stall = (state_q != S_IDLE);
	assign pair_acc   = pair_valid && !pair_stall;

	assign sxy_mag = sxy_q[SXY_W-1] ? SXY_W'(-sxy_q) : SXY_W'(sxy_q);
	assign sx_mag  = sx_q[SX_W-1] ? SX_W'(-sx_q) : SX_W'(sx_q);
	assign sy_mag  = sy_q[SX_W-1] ? SX_W'(-sy_q) : SX_W'(sy_q);
	assign num_mag = num_neg_q ? PROD_W'(0) - num_q : num_q;
	assign q_next  = acc[ACC_W-1] ? q_q : cand_q;

	// leave the op sequence on a non-positive variance or after the last bit
	assign den_ok    = ($signed(dx_q) > 0) && ($signed(acc[PROD_W-1:0]) > 0);
	assign store_fin = (op_q == OP_DY2 && !den_ok) || (op_q == OP_TST && bit_q == '0);

	always_comb begin
		req = '0;
		unique case (state_q)
			S_P1: begin
				req.issue = 1'b1;
				req.a     = LIMB_W'(xm_q);
				req.b     = LIMB_W'(ym_q);
				req.neg   = sxor_q;
				req.dest  = DST_XY;
			end
			S_P2: begin
				req.issue = 1'b1;
				req.a     = LIMB_W'(xm_q);
				req.b     = LIMB_W'(xm_q);
				req.dest  = DST_XX;
			end
			S_P3: begin
				req.issue = 1'b1;
				req.a     = LIMB_W'(ym_q);
				req.b     = LIMB_W'(ym_q);
				req.dest  = DST_YY;
			end
			S_ISSUE: begin
				req.issue = 1'b1;
				req.a     = opa_q[{i_q, 5'd0} +: LIMB_W];
				req.b     = opb_q[{j_q, 5'd0} +: LIMB_W];
				req.sh    = 3'({1'b0, i_q} + {1'b0, j_q});
				req.neg   = neg_q;
				req.dest  = DST_ACC;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	// the second half of each difference keeps adding into the first half
	assign acc_load = (state_q == S_STORE) &&
		!(op_q == OP_NUM1 || op_q == OP_DX1 || op_q == OP_DY1);
	assign acc_init = (op_q == OP_SQ) ? lim_q : '0;

	always_comb begin
		if (!fin_ok_q) begin
			coef_w = '0;
		end else if (num_neg_q) begin
			coef_w = COEF_W'(0) - q_q;
		end else if (q_q[COEF_W-1]) begin
			coef_w = {1'b0, {(COEF_W-1){1'b1}}};
		end else begin
			coef_w = q_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_START;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
			sxx_q       <= '0;
			syy_q       <= '0;
			fin_ok_q    <= 1'b0;
			res_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			bit_q       <= '0;
		end else begin
			if (rsp.valid) begin
				case (rsp.dest)
					DST_XY: sxy_q <= rsp.neg ? sxy_q - SXY_W'(rsp.p) : sxy_q + SXY_W'(rsp.p);
					DST_XX: sxx_q <= sxx_q + SSQ_W'(rsp.p);
					DST_YY: syy_q <= syy_q + SSQ_W'(rsp.p);
					default: ;
				endcase
			end

			// the finish state reloads the valid itself
			if (res_valid_q && !res_stall && state_q != S_FIN) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (pair_acc) begin
						if (cnt_q < CNT_W'(MAX_PAIRS)) begin
							sx_q    <= sx_q + SX_W'(x_v);
							sy_q    <= sy_q + SX_W'(y_v);
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_P1;
						end else begin
							ovf_q    <= 1'b1;
							fin_ok_q <= 1'b0;
							if (last) begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: begin
					state_q <= last_q ? S_PDRAIN : S_IDLE;
				end
				S_PDRAIN: begin
					op_q    <= OP_START;
					state_q <= S_STORE;
				end
				S_ISSUE: begin
					if (j_q == lbl_q) begin
						j_q <= '0;
						if (i_q == lal_q) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_STORE;
				S_STORE: begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= store_fin ? S_FIN : S_ISSUE;
					case (op_q)
						OP_START: op_q <= OP_NUM1;
						OP_NUM1:  op_q <= OP_NUM2;
						OP_NUM2:  op_q <= OP_DX1;
						OP_DX1:   op_q <= OP_DX2;
						OP_DX2:   op_q <= OP_DY1;
						OP_DY1:   op_q <= OP_DY2;
						OP_DY2: begin
							if (den_ok) begin
								op_q <= OP_DEN;
							end else begin
								fin_ok_q <= 1'b0;
							end
						end
						OP_DEN:   op_q <= OP_LIM;
						OP_LIM: begin
							bit_q <= 4'(COEF_W - 1);
							op_q  <= OP_SQ;
						end
						OP_SQ:    op_q <= OP_TST;
						OP_TST: begin
							if (bit_q == '0) begin
								fin_ok_q <= 1'b1;
							end else begin
								bit_q <= bit_q - 1'b1;
								op_q  <= OP_SQ;
							end
						end
						default: op_q <= OP_START;
					endcase
				end
				S_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						sx_q        <= '0;
						sy_q        <= '0;
						sxy_q       <= '0;
						sxx_q       <= '0;
						syy_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers: latched pair, operands of the next op, intermediate results
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pair_acc) begin
			xm_q   <= x_v[SAMPLE_W-1] ? SAMPLE_W'(-x_v) : SAMPLE_W'(x_v);
			ym_q   <= y_v[SAMPLE_W-1] ? SAMPLE_W'(-y_v) : SAMPLE_W'(y_v);
			sxor_q <= x_v[SAMPLE_W-1] ^ y_v[SAMPLE_W-1];
			last_q <= last;
		end

		if (state_q == S_STORE) begin
			case (op_q)
				OP_START: begin
					opa_q <= OPD_W'(cnt_q);
					opb_q <= OPD_W'(sxy_mag);
					lal_q <= 2'd0;
					lbl_q <= 2'd1;
					neg_q <= sxy_q[SXY_W-1];
				end
				OP_NUM1: begin
					opa_q <= OPD_W'(sx_mag);
					opb_q <= OPD_W'(sy_mag);
					lal_q <= 2'd0;
					lbl_q <= 2'd0;
					neg_q <= ~(sx_q[SX_W-1] ^ sy_q[SX_W-1]);
				end
				OP_NUM2: begin
					num_q     <= acc[PROD_W-1:0];
					num_neg_q <= acc[PROD_W-1];
					opa_q     <= OPD_W'(cnt_q);
					opb_q     <= OPD_W'(sxx_q);
					lal_q     <= 2'd0;
					lbl_q     <= 2'd1;
					neg_q     <= 1'b0;
				end
				OP_DX1: begin
					opa_q <= OPD_W'(sx_mag);
					opb_q <= OPD_W'(sx_mag);
					lal_q <= 2'd0;
					lbl_q <= 2'd0;
					neg_q <= 1'b1;
				end
				OP_DX2: begin
					dx_q  <= acc[PROD_W-1:0];
					opa_q <= OPD_W'(cnt_q);
					opb_q <= OPD_W'(syy_q);
					lal_q <= 2'd0;
					lbl_q <= 2'd1;
					neg_q <= 1'b0;
				end
				OP_DY1: begin
					opa_q <= OPD_W'(sy_mag);
					opb_q <= OPD_W'(sy_mag);
					lal_q <= 2'd0;
					lbl_q <= 2'd0;
					neg_q <= 1'b1;
				end
				OP_DY2: begin
					opa_q <= OPD_W'(dx_q);
					opb_q <= OPD_W'(acc[PROD_W-1:0]);
					lal_q <= 2'd1;
					lbl_q <= 2'd1;
					neg_q <= 1'b0;
				end
				OP_DEN: begin
					// scale by 2^15 on each side so the square carries 2^30
					den_q <= acc[OPD_W-1:0];
					opa_q <= OPD_W'(num_mag) << (COEF_W - 1);
					opb_q <= OPD_W'(num_mag) << (COEF_W - 1);
					lal_q <= 2'd2;
					lbl_q <= 2'd2;
					neg_q <= 1'b0;
				end
				OP_LIM: begin
					lim_q  <= acc;
					q_q    <= '0;
					cand_q <= {1'b1, {(COEF_W-1){1'b0}}};
					opa_q  <= OPD_W'({1'b1, {(COEF_W-1){1'b0}}});
					opb_q  <= OPD_W'({1'b1, {(COEF_W-1){1'b0}}});
					lal_q  <= 2'd0;
					lbl_q  <= 2'd0;
					neg_q  <= 1'b0;
				end
				OP_SQ: begin
					// test lim - cand^2 * den for sign
					opa_q <= OPD_W'(acc[LIMB_W-1:0]);
					opb_q <= den_q;
					lal_q <= 2'd0;
					lbl_q <= 2'd3;
					neg_q <= 1'b1;
				end
				OP_TST: begin
					q_q    <= q_next;
					cand_q <= q_next | (COEF_W'(1) << (bit_q - 1'b1));
					opa_q  <= OPD_W'(q_next | (COEF_W'(1) << (bit_q - 1'b1)));
					opb_q  <= OPD_W'(q_next | (COEF_W'(1) << (bit_q - 1'b1)));
					lal_q  <= 2'd0;
					lbl_q  <= 2'd0;
					neg_q  <= 1'b0;
				end
				default: ;
			endcase
		end

		if (state_q == S_FIN && (!res_valid_q || !res_stall)) begin
			coef_q      <= coef_w;
			valid_res_q <= fin_ok_q;
			pairs_q     <= cnt_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign coefficient = coef_q;
	assign valid_res   = valid_res_q;
	assign pairs_used  = pairs_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count beyond limit");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_W'(MAX_PAIRS))
		else $error("overflow flagged below the pair limit");

	a_store_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STORE |-> !rsp.valid)
		else $error("product still in flight at op boundary");

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && fin_ok_q) |-> q_q <= 16'd32768)
		else $error("root search above unity");

endmodule

FILE: hw/rtl/pcc_mac.sv
// ----------------------------------------------------------------------------
// pcc_mac
// Shared 32x32 multiplier with a registered product, and a wide accumulator
// that adds or subtracts limb-aligned partial products.
// ----------------------------------------------------------------------------
module pcc_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcc_pkg::mul_req_t             req,
	input  logic                          acc_load,
	input  logic [pcc_pkg::ACC_W-1:0]     acc_init,
	output logic [pcc_pkg::ACC_W-1:0]     acc,
	output pcc_pkg::mul_rsp_t             rsp
);
	import pcc_pkg::*;

	mul_rsp_t           rsp_s1;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   pp_aligned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_s1 <= '0;
		end else begin
			rsp_s1.valid <= req.issue;
			rsp_s1.p     <= PROD_W'(req.a) * PROD_W'(req.b);
			rsp_s1.sh    <= req.sh;
			rsp_s1.neg   <= req.neg;
			rsp_s1.dest  <= req.dest;
		end
	end

	// place the product at its limb offset; offsets past the top drop out
	assign pp_aligned = ACC_W'(rsp_s1.p) << {rsp_s1.sh, 5'd0};

	always_ff @(posedge clk) begin
		if (acc_load) begin
			acc_q <= acc_init;
		end else if (rsp_s1.valid && rsp_s1.dest == DST_ACC) begin
			acc_q <= rsp_s1.neg ? acc_q - pp_aligned : acc_q + pp_aligned;
		end
	end

	assign acc = acc_q;
	assign rsp = rsp_s1;

endmodule
